// ----- rtl/ffca_pkg.sv -----
// Shared constants, types and codes of the first-fit coalescing allocator.
// No dependencies; imported by the allocator top level, the checker and the testbench.
package ffca_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ADDR_BITS     = 16;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W = ADDR_BITS + 1;

    localparam int S_TDATA_W = ((LEN_W + ADDR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 + ADDR_BITS + 7) / 8) * 8;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;

    // Size of the whole address space, as a length
    localparam logic [LEN_W-1:0] SPACE_LEN = {1'b1, {ADDR_BITS{1'b0}}};

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic REG_POOL_START  = 1'b0;
    localparam logic REG_POOL_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_NOFIT = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [LEN_W-1:0]     len;
    } seg_t;

endpackage

// ----- rtl/first_fit_coalescing_allocator_top.sv -----
// Flow: a zero size goes straight to the result; otherwise the entries are scanned in order,
// the table is updated, entries may be moved to close or open a slot, and the result is loaded
// once the output register is free. One item at a time: s_tready returns the cycle after the
// result is loaded, unless a table rebuild is pending.
// Reset: control state clears, then one cycle rebuilds entry 0 as the whole pool while no item
// is accepted; a write of pool_length rebuilds the table the same way.
// Top level of the first-fit free-segment allocator with coalescing release.
// Depends on ffca_pkg.
module first_fit_coalescing_allocator_top
    import ffca_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // block_size, block_start, zero pad
    input  logic                 s_tuser,   // req_type

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, granted_start, zero pad
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_SHIFT  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    // Configuration registers
    logic [ADDR_BITS-1:0] pool_start_reg;
    logic [LEN_W-1:0]     pool_length_reg;
    logic                 cfg_wr;

    // Control
    state_t               state_reg, state_next;
    logic                 rebuild_reg, rebuild_next;
    logic [CNT_W-1:0]     seg_count_reg, seg_count_next;
    logic                 m_valid_reg, m_valid_next;

    // Request payload
    logic                 req_type_reg, req_type_next;
    logic [LEN_W-1:0]     need_reg, need_next;
    logic [ADDR_BITS-1:0] s_reg, s_next;
    logic [LEN_W-1:0]     size_reg, size_next;
    logic [LEN_W-1:0]     e_reg, e_next;

    // Scan and merge working registers
    logic [CNT_W-1:0]     ev_idx_reg, ev_idx_next;
    logic [CNT_W-1:0]     p_reg, p_next;
    logic                 cur_ok_reg, cur_ok_next;
    logic [ADDR_BITS-1:0] cur_base_reg, cur_base_next;
    logic [LEN_W-1:0]     cur_len_reg, cur_len_next;
    logic [LEN_W-1:0]     cur_end_reg, cur_end_next;
    logic [ADDR_BITS-1:0] prev_base_reg, prev_base_next;
    logic [LEN_W-1:0]     prev_end_reg, prev_end_next;

    // Entry mover
    logic [CNT_W-1:0]     sh_left_reg, sh_left_next;
    logic [IDX_W-1:0]     sh_ptr_reg, sh_ptr_next;
    logic [IDX_W-1:0]     last_src_reg, last_src_next;
    logic                 sh_have_reg, sh_have_next;
    logic                 sh_up_reg, sh_up_next;
    logic                 ins_reg, ins_next;

    // Result
    status_t              status_reg, status_next;
    logic [ADDR_BITS-1:0] granted_reg, granted_next;
    status_t              out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0] out_granted_reg, out_granted_next;

    // Segment memory
    seg_t                 seg_mem [TABLE_ENTRIES];
    seg_t                 rd_data_reg;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    seg_t                 wr_data;
    logic [IDX_W-1:0]     rd_addr;

    // Input fields
    logic [LEN_W-1:0]     in_size;
    logic [ADDR_BITS-1:0] in_start;
    logic [LEN_W-1:0]     in_room;
    logic [LEN_W-1:0]     pool_room;
    logic [LEN_W-1:0]     pool_len_clip;

    // Merge arithmetic
    logic [CNT_W-1:0]     p_m1;
    logic [CNT_W-1:0]     p_p1;
    logic                 mp;
    logic                 mn;
    logic [LEN_W-1:0]     hi_pe;
    logic [LEN_W-1:0]     hi_ne;
    logic [LEN_W-1:0]     hi_all;
    logic [LEN_W-1:0]     rd_end;

    assign in_size  = s_tdata[LEN_W-1:0];
    assign in_start = s_tdata[LEN_W +: ADDR_BITS];
    assign in_room  = SPACE_LEN - {1'b0, in_start};

    assign pool_room     = SPACE_LEN - {1'b0, pool_start_reg};
    assign pool_len_clip = (pool_length_reg > pool_room) ? pool_room : pool_length_reg;

    assign rd_end = {1'b0, rd_data_reg.base} + rd_data_reg.len;

    assign p_m1   = p_reg - CNT_W'(1);
    assign p_p1   = p_reg + CNT_W'(1);
    assign mp     = (p_reg != '0) && (prev_end_reg >= {1'b0, s_reg});
    assign mn     = cur_ok_reg && (e_reg >= {1'b0, cur_base_reg});
    assign hi_pe  = (prev_end_reg > e_reg) ? prev_end_reg : e_reg;
    assign hi_ne  = (cur_end_reg > e_reg) ? cur_end_reg : e_reg;
    assign hi_all = (hi_pe > cur_end_reg) ? hi_pe : cur_end_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[REG_SEL_BIT] == REG_POOL_LENGTH) ? PDATA_W'(pool_length_reg)
                                                           : PDATA_W'(pool_start_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_start_reg  <= '0;
            pool_length_reg <= SPACE_LEN;
        end else if (cfg_wr) begin
            if (paddr[REG_SEL_BIT] == REG_POOL_LENGTH) begin
                pool_length_reg <= pwdata[LEN_W-1:0];
            end else begin
                pool_start_reg <= pwdata[ADDR_BITS-1:0];
            end
        end
    end

    // Segment memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seg_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= seg_mem[rd_addr];
    end

    assign s_tready = (state_reg == ST_IDLE) && !rebuild_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_granted_reg, out_status_reg});

    always_comb begin
        state_next       = state_reg;
        rebuild_next     = rebuild_reg;
        seg_count_next   = seg_count_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        req_type_next    = req_type_reg;
        need_next        = need_reg;
        s_next           = s_reg;
        size_next        = size_reg;
        e_next           = e_reg;
        ev_idx_next      = ev_idx_reg;
        p_next           = p_reg;
        cur_ok_next      = cur_ok_reg;
        cur_base_next    = cur_base_reg;
        cur_len_next     = cur_len_reg;
        cur_end_next     = cur_end_reg;
        prev_base_next   = prev_base_reg;
        prev_end_next    = prev_end_reg;
        sh_left_next     = sh_left_reg;
        sh_ptr_next      = sh_ptr_reg;
        last_src_next    = last_src_reg;
        sh_have_next     = sh_have_reg;
        sh_up_next       = sh_up_reg;
        ins_next         = ins_reg;
        status_next      = status_reg;
        granted_next     = granted_reg;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_addr          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (rebuild_reg) begin
                    wr_en          = 1'b1;
                    wr_data.base   = pool_start_reg;
                    wr_data.len    = pool_len_clip;
                    seg_count_next = (pool_len_clip != '0) ? CNT_W'(1) : '0;
                    rebuild_next   = 1'b0;
                end else if (s_tvalid) begin
                    req_type_next = s_tuser;
                    need_next     = in_size;
                    s_next        = in_start;
                    size_next     = (in_size > in_room) ? in_room : in_size;
                    e_next        = (in_size > in_room) ? SPACE_LEN
                                                        : {1'b0, in_start} + in_size;
                    ev_idx_next   = '0;
                    granted_next  = '0;
                    if (in_size == '0) begin
                        status_next = (s_tuser == REQ_ALLOC) ? STATUS_NOFIT : STATUS_DONE;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                rd_addr = IDX_W'(ev_idx_reg + CNT_W'(1));
                if (req_type_reg == REQ_ALLOC) begin
                    if (ev_idx_reg == seg_count_reg) begin
                        status_next = STATUS_NOFIT;
                        state_next  = ST_DONE;
                    end else if (rd_data_reg.len >= need_reg) begin
                        p_next        = ev_idx_reg;
                        cur_base_next = rd_data_reg.base;
                        cur_len_next  = rd_data_reg.len;
                        state_next    = ST_UPDATE;
                    end else begin
                        ev_idx_next = ev_idx_reg + CNT_W'(1);
                    end
                end else begin
                    if (ev_idx_reg == seg_count_reg || rd_data_reg.base > s_reg) begin
                        p_next        = ev_idx_reg;
                        cur_ok_next   = (ev_idx_reg != seg_count_reg);
                        cur_base_next = rd_data_reg.base;
                        cur_end_next  = rd_end;
                        state_next    = ST_UPDATE;
                    end else begin
                        // Remember the entry just below the released block
                        prev_base_next = rd_data_reg.base;
                        prev_end_next  = rd_end;
                        ev_idx_next    = ev_idx_reg + CNT_W'(1);
                    end
                end
            end

            ST_UPDATE: begin
                status_next  = STATUS_DONE;
                sh_have_next = 1'b0;
                ins_next     = 1'b0;
                state_next   = ST_DONE;
                if (req_type_reg == REQ_ALLOC) begin
                    granted_next = cur_base_reg;
                    if (cur_len_reg == need_reg) begin
                        // Exact fit: close the gap by moving later entries down
                        seg_count_next = seg_count_reg - CNT_W'(1);
                        sh_left_next   = seg_count_reg - p_p1;
                        sh_ptr_next    = p_p1[IDX_W-1:0];
                        sh_up_next     = 1'b0;
                        state_next     = ST_SHIFT;
                    end else begin
                        wr_en        = 1'b1;
                        wr_addr      = p_reg[IDX_W-1:0];
                        wr_data.base = ADDR_BITS'({1'b0, cur_base_reg} + need_reg);
                        wr_data.len  = cur_len_reg - need_reg;
                    end
                end else if (mp && mn) begin
                    wr_en          = 1'b1;
                    wr_addr        = p_m1[IDX_W-1:0];
                    wr_data.base   = prev_base_reg;
                    wr_data.len    = hi_all - {1'b0, prev_base_reg};
                    seg_count_next = seg_count_reg - CNT_W'(1);
                    sh_left_next   = seg_count_reg - p_p1;
                    sh_ptr_next    = p_p1[IDX_W-1:0];
                    sh_up_next     = 1'b0;
                    state_next     = ST_SHIFT;
                end else if (mp) begin
                    wr_en        = 1'b1;
                    wr_addr      = p_m1[IDX_W-1:0];
                    wr_data.base = prev_base_reg;
                    wr_data.len  = hi_pe - {1'b0, prev_base_reg};
                end else if (mn) begin
                    wr_en        = 1'b1;
                    wr_addr      = p_reg[IDX_W-1:0];
                    wr_data.base = s_reg;
                    wr_data.len  = hi_ne - {1'b0, s_reg};
                end else if (seg_count_reg == CNT_W'(TABLE_ENTRIES)) begin
                    status_next = STATUS_FULL;
                end else begin
                    // Open a slot at p by moving the upper entries up, top first
                    seg_count_next = seg_count_reg + CNT_W'(1);
                    sh_left_next   = seg_count_reg - p_reg;
                    sh_ptr_next    = IDX_W'(seg_count_reg - CNT_W'(1));
                    sh_up_next     = 1'b1;
                    ins_next       = 1'b1;
                    state_next     = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                if (sh_have_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = sh_up_reg ? last_src_reg + IDX_W'(1) : last_src_reg - IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                if (sh_left_reg != '0) begin
                    rd_addr       = sh_ptr_reg;
                    last_src_next = sh_ptr_reg;
                    sh_ptr_next   = sh_up_reg ? sh_ptr_reg - IDX_W'(1) : sh_ptr_reg + IDX_W'(1);
                    sh_left_next  = sh_left_reg - CNT_W'(1);
                    sh_have_next  = 1'b1;
                end else begin
                    sh_have_next = 1'b0;
                    if (!sh_have_reg) begin
                        if (ins_reg) begin
                            wr_en        = 1'b1;
                            wr_addr      = p_reg[IDX_W-1:0];
                            wr_data.base = s_reg;
                            wr_data.len  = size_reg;
                        end
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next     = 1'b1;
                    out_status_next  = status_reg;
                    out_granted_next = (status_reg == STATUS_DONE) ? granted_reg : '0;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr && paddr[REG_SEL_BIT] == REG_POOL_LENGTH) begin
            rebuild_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rebuild_reg   <= 1'b1;
            seg_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rebuild_reg   <= rebuild_next;
            seg_count_reg <= seg_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_type_reg    <= req_type_next;
        need_reg        <= need_next;
        s_reg           <= s_next;
        size_reg        <= size_next;
        e_reg           <= e_next;
        ev_idx_reg      <= ev_idx_next;
        p_reg           <= p_next;
        cur_ok_reg      <= cur_ok_next;
        cur_base_reg    <= cur_base_next;
        cur_len_reg     <= cur_len_next;
        cur_end_reg     <= cur_end_next;
        prev_base_reg   <= prev_base_next;
        prev_end_reg    <= prev_end_next;
        sh_left_reg     <= sh_left_next;
        sh_ptr_reg      <= sh_ptr_next;
        last_src_reg    <= last_src_next;
        sh_have_reg     <= sh_have_next;
        sh_up_reg       <= sh_up_next;
        ins_reg         <= ins_next;
        status_reg      <= status_next;
        granted_reg     <= granted_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("segment count above table size");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item still in work");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> ev_idx_reg <= seg_count_reg)
        else $error("scan index past last segment");

    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_status_reg != STATUS_DONE |-> out_granted_reg == '0)
        else $error("granted start nonzero on failed request");

endmodule

// ----- sim/ffca_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the first-fit coalescing allocator: keeps its own copy of the free table,
// predicts one reply per accepted request and compares replies in order. Depends on ffca_pkg.
module free_table_checker
    import ffca_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    input  logic                 pready,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // block_size, block_start, zero pad
    input  logic                 s_tuser,   // req_type
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // status, granted_start, zero pad
    output int                   mismatch_count,
    output int                   replies_owed
);

    localparam int SPACE    = 1 << ADDR_BITS;
    localparam int M_PAD_W  = M_TDATA_W - 2 - ADDR_BITS;
    localparam int MAX_LOGS = 60;

    typedef struct packed {
        status_t              status;
        logic [ADDR_BITS-1:0] granted;
    } reply_t;

    logic [ADDR_BITS-1:0] seg_start [TABLE_ENTRIES];
    logic [LEN_W-1:0]     seg_size  [TABLE_ENTRIES];
    int                   live_segs;
    logic [ADDR_BITS-1:0] cfg_start;
    logic [LEN_W-1:0]     cfg_length;
    reply_t               replies_due [$];
    int                   faults;

    function automatic int clip_to_space(int base, int len);
        return (len > SPACE - base) ? SPACE - base : len;
    endfunction

    function automatic void rebuild_table();
        int len;
        len = clip_to_space(cfg_start, cfg_length);
        seg_start[0] = cfg_start;
        seg_size[0]  = len;
        live_segs    = (len != 0) ? 1 : 0;
    endfunction

    function automatic void drop_entry(int idx);
        int k;
        for (k = idx; k + 1 < live_segs; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_size[k]  = seg_size[k+1];
        end
        live_segs--;
    endfunction

    function automatic reply_t grant_block(int need);
        reply_t r;
        int     i;
        bit     hit;
        r.status  = STATUS_NOFIT;
        r.granted = '0;
        hit       = 1'b0;
        if (need == 0) return r;
        for (i = 0; i < live_segs && !hit; i++) begin
            if (seg_size[i] >= need) begin
                hit       = 1'b1;
                r.status  = STATUS_DONE;
                r.granted = seg_start[i];
                // exact fit removes the entry, otherwise shrink it from the front
                if (seg_size[i] == need) begin
                    drop_entry(i);
                end else begin
                    seg_start[i] = seg_start[i] + need;
                    seg_size[i]  = seg_size[i] - need;
                end
            end
        end
        return r;
    endfunction

    function automatic status_t return_block(int s, int size);
        int e, p, k, prev_end, next_end, span_end;
        bit mp, mn;
        size = clip_to_space(s, size);
        if (size == 0) return STATUS_DONE;
        e  = s + size;
        p  = 0;
        mp = 1'b0;
        mn = 1'b0;
        while (p < live_segs && seg_start[p] <= s) p++;
        if (p > 0) mp = (int'(seg_start[p-1]) + int'(seg_size[p-1]) >= s);
        if (p < live_segs) mn = (e >= int'(seg_start[p]));
        if (mp && mn) begin
            prev_end = int'(seg_start[p-1]) + int'(seg_size[p-1]);
            next_end = int'(seg_start[p]) + int'(seg_size[p]);
            span_end = (prev_end > next_end) ? prev_end : next_end;
            if (e > span_end) span_end = e;
            seg_size[p-1] = span_end - int'(seg_start[p-1]);
            drop_entry(p);
        end else if (mp) begin
            prev_end = int'(seg_start[p-1]) + int'(seg_size[p-1]);
            span_end = (prev_end > e) ? prev_end : e;
            seg_size[p-1] = span_end - int'(seg_start[p-1]);
        end else if (mn) begin
            next_end = int'(seg_start[p]) + int'(seg_size[p]);
            span_end = (next_end > e) ? next_end : e;
            seg_start[p] = s;
            seg_size[p]  = span_end - s;
        end else begin
            if (live_segs >= TABLE_ENTRIES) return STATUS_FULL;
            for (k = live_segs; k > p; k--) begin
                seg_start[k] = seg_start[k-1];
                seg_size[k]  = seg_size[k-1];
            end
            seg_start[p] = s;
            seg_size[p]  = size;
            live_segs++;
        end
        return STATUS_DONE;
    endfunction

    always @(posedge aclk) begin : watch
        reply_t               want;
        logic [1:0]           got_status;
        logic [ADDR_BITS-1:0] got_granted;
        logic [M_PAD_W-1:0]   got_pad;
        if (!aresetn) begin
            cfg_start  = '0;
            cfg_length = SPACE_LEN;
            rebuild_table();
            replies_due.delete();
            faults = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[REG_SEL_BIT] == REG_POOL_LENGTH) begin
                    cfg_length = pwdata[LEN_W-1:0];
                    rebuild_table();
                end else begin
                    cfg_start = pwdata[ADDR_BITS-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_ALLOC) begin
                    want = grant_block(s_tdata[LEN_W-1:0]);
                end else begin
                    want.status  = return_block(s_tdata[LEN_W +: ADDR_BITS],
                                                s_tdata[LEN_W-1:0]);
                    want.granted = '0;
                end
                replies_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got_status  = m_tdata[1:0];
                got_granted = m_tdata[2 +: ADDR_BITS];
                got_pad     = m_tdata[M_TDATA_W-1 -: M_PAD_W];
                if (replies_due.size() == 0) begin
                    faults++;
                    if (faults <= MAX_LOGS)
                        $display("%0t: unexpected item, expected none, actual status %0d start %0h",
                                 $time, got_status, got_granted);
                end else begin
                    want = replies_due.pop_front();
                    if (got_status != want.status) begin
                        faults++;
                        if (faults <= MAX_LOGS)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, got_status);
                    end
                    if (got_granted != want.granted) begin
                        faults++;
                        if (faults <= MAX_LOGS)
                            $display("%0t: granted_start expected %0h actual %0h",
                                     $time, want.granted, got_granted);
                    end
                    if (got_pad != '0) begin
                        faults++;
                        if (faults <= MAX_LOGS)
                            $display("%0t: tdata pad expected 0 actual %0h",
                                     $time, got_pad);
                    end
                end
            end
        end
        mismatch_count <= faults;
        replies_owed   <= replies_due.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the first-fit coalescing allocator: drives requests and pool settings,
// varies idling on both channels; free_table_checker does the checking. Depends on ffca_pkg.
module tb_top;
    import ffca_pkg::*;

    localparam int SPACE = 1 << ADDR_BITS;
    localparam int S_PAD_W = S_TDATA_W - LEN_W - ADDR_BITS;
    localparam logic [PADDR_W-1:0] ADDR_POOL_START  = {REG_POOL_START, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_POOL_LENGTH = {REG_POOL_LENGTH, 2'b00};

    typedef struct packed {
        logic             req;
        logic [LEN_W-1:0] size;
    } ask_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     size;
    } held_block_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // block_size, block_start, zero pad
    logic                 s_tuser  = 1'b0; // req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // status, granted_start, zero pad

    int          mismatch_count;
    int          replies_owed;
    int          idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    int          phase_no  = 0;
    bit          hold_req  = 1'b0;
    bit          hold_taken;
    int          hold_cnt;
    ask_t        asks [$];
    held_block_t held [$];

    always #5 aclk = ~aclk;

    first_fit_coalescing_allocator_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    free_table_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .replies_owed   (replies_owed)
    );

    // Receiver: random stalls, plus one long hold-off so the input side backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_cnt   <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt   <= 400;
            m_tready   <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= ((idle_mode == 2) ? 70 :
                                               (idle_mode == 3) ? 12 : 0);
        end
    end

    // Collect granted blocks so later releases can hand them back
    always @(posedge aclk) begin : harvest
        ask_t        a;
        held_block_t b;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                a.req  = s_tuser;
                a.size = s_tdata[LEN_W-1:0];
                asks.push_back(a);
            end
            if (m_tvalid && m_tready && asks.size() != 0) begin
                a = asks.pop_front();
                if (a.req == REQ_ALLOC && m_tdata[1:0] == STATUS_DONE) begin
                    b.start = m_tdata[2 +: ADDR_BITS];
                    b.size  = a.size;
                    held.push_back(b);
                end
            end
        end
    end

    task automatic send_item(input logic req, input int size, input int start);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 70 : (idle_mode == 3) ? 12 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{S_PAD_W{1'b0}}, start[ADDR_BITS-1:0], size[LEN_W-1:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait for every outstanding reply
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_pool(input int start, input int length);
        settle();
        reg_write(ADDR_POOL_START, start);
        reg_write(ADDR_POOL_LENGTH, length);
        held.delete();
    endtask

    function automatic int draw_size(int small_max);
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) return 0;
        if (pick < 6) return SPACE;
        if (pick < 10) return $urandom_range(SPACE, 1);
        return $urandom_range(small_max, 1);
    endfunction

    task automatic run_random(input int count, input int small_max,
                              input int span_base, input int span_len);
        int          k, idx, start;
        held_block_t blk;
        for (k = 0; k < count; k++) begin
            idle_mode = ((k / 50) + phase_no) % 4;
            if ($urandom_range(99) < 55) begin
                send_item(REQ_ALLOC, draw_size(small_max), $urandom_range(SPACE - 1));
            end else if (held.size() != 0 && $urandom_range(99) < 75) begin
                idx = $urandom_range(held.size() - 1);
                blk = held[idx];
                held.delete(idx);
                send_item(REQ_RELEASE, blk.size, blk.start);
            end else begin
                if ($urandom_range(99) < 70)
                    start = (span_base + $urandom_range(span_len - 1)) % SPACE;
                else
                    start = $urandom_range(SPACE - 1);
                send_item(REQ_RELEASE, draw_size(small_max), start);
            end
        end
        phase_no++;
    endtask

    initial begin : stimulus
        int k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero sizes, whole space, clipping, merges, table full, exact fit
        send_item(REQ_ALLOC, 0, 16'hFFFF);
        send_item(REQ_ALLOC, SPACE, 0);
        send_item(REQ_ALLOC, 1, 0);
        send_item(REQ_RELEASE, SPACE, 16'hFFFF);
        send_item(REQ_RELEASE, 0, 0);
        for (k = 0; k < 14; k++)
            send_item(REQ_RELEASE, 1, k * 256);
        send_item(REQ_RELEASE, 1, 16'h2000);
        send_item(REQ_RELEASE, 1, 16'h3000);
        send_item(REQ_RELEASE, 16'h100, 16'h100);
        send_item(REQ_RELEASE, 16'h80, 0);
        send_item(REQ_RELEASE, 16'hF, 16'hFFF0);
        send_item(REQ_ALLOC, 16'h101, 16'hAAAA);
        send_item(REQ_ALLOC, 2, 16'h5555);

        set_pool(0, SPACE);
        run_random(250, 256, 0, SPACE);

        set_pool(16'h1000, 512);
        hold_req = 1'b1;
        run_random(260, 16, 16'h1000, 512);

        // New start alone leaves the table as it is
        settle();
        reg_write(ADDR_POOL_START, 16'hFF00);
        run_random(100, 16, 16'h1000, 512);

        // Pool runs past the address space and gets clipped
        settle();
        reg_write(ADDR_POOL_LENGTH, SPACE);
        held.delete();
        run_random(250, 8, 16'hFF00, 256);

        set_pool(0, 0);
        run_random(150, 32, 0, 1024);

        set_pool(16'h8000, 4096);
        run_random(250, 64, 16'h8000, 4096);

        set_pool(16'hFFFF, 1);
        run_random(80, 2, 16'hFFFF, 1);

        set_pool(0, SPACE);
        run_random(250, 4096, 0, SPACE);

        settle();
        repeat (2 * TABLE_ENTRIES + 8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- first_fit_coalescing_allocator_top.f -----
rtl/ffca_pkg.sv
rtl/first_fit_coalescing_allocator_top.sv
sim/ffca_checker.sv
sim/tb_top.sv
